@@ src/assert_macros.svh @@
// assertion macros for the mapper rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check on every rising clock edge outside of reset
`define ASSERT_ON(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("%m: assertion failed");

// check on every rising clock edge, also during reset
`define ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk_i) (prop)) \
    else $error("%m: assertion failed");

`endif

@@ src/fpa_pkg.sv @@
// types, code unit constants and per-unit processing function for the punctuation mapper
package fpa_pkg;

  localparam int unsigned UnitW = 16;

  // ascii code units that steer the scanner
  localparam logic [UnitW-1:0] CuBslash  = 16'h005C;
  localparam logic [UnitW-1:0] CuDquote  = 16'h0022;
  localparam logic [UnitW-1:0] CuSquote  = 16'h0027;
  localparam logic [UnitW-1:0] CuSlash   = 16'h002F;
  localparam logic [UnitW-1:0] CuStar    = 16'h002A;
  localparam logic [UnitW-1:0] CuNewline = 16'h000A;

  // scanner flags
  typedef struct packed {
    logic str_lit;
    logic chr_lit;
    logic line_cmt;
    logic block_cmt;
    logic esc;
    logic skip;
  } flags_t;

  // one result word
  typedef struct packed {
    logic [UnitW-1:0] unit;
    logic             mapped;
    logic             last;
  } res_t;

  // processing of one unit: result and updated flags
  typedef struct packed {
    flags_t           st;
    logic [UnitW-1:0] unit;
    logic             mapped;
  } proc_t;

  // full-width / cjk punctuation lookup, hit flag in bit 8
  function automatic logic [8:0] map_punct(logic [UnitW-1:0] c);
    logic [8:0] r;
    unique case (c)
      16'hFF1B: r = {1'b1, 8'h3B};
      16'hFF1A: r = {1'b1, 8'h3A};
      16'hFF0C: r = {1'b1, 8'h2C};
      16'h3002: r = {1'b1, 8'h2E};
      16'hFF01: r = {1'b1, 8'h21};
      16'hFF1F: r = {1'b1, 8'h3F};
      16'hFF08: r = {1'b1, 8'h28};
      16'hFF09: r = {1'b1, 8'h29};
      16'h3010: r = {1'b1, 8'h5B};
      16'h3011: r = {1'b1, 8'h5D};
      16'h300A: r = {1'b1, 8'h3C};
      16'h300B: r = {1'b1, 8'h3E};
      16'h201C: r = {1'b1, 8'h22};
      16'h201D: r = {1'b1, 8'h22};
      16'h2018: r = {1'b1, 8'h27};
      16'h2019: r = {1'b1, 8'h27};
      16'h3001: r = {1'b1, 8'h5C};
      16'hFF5B: r = {1'b1, 8'h7B};
      16'hFF5D: r = {1'b1, 8'h7D};
      default:  r = 9'h000;
    endcase
    return r;
  endfunction

  // scan one unit c with optional lookahead n
  function automatic proc_t proc_unit(flags_t st, logic [UnitW-1:0] c, logic has_next,
                                      logic [UnitW-1:0] n);
    proc_t      r;
    logic       done;
    logic [8:0] hit;
    r.st     = st;
    r.unit   = c;
    r.mapped = 1'b0;
    done     = 1'b0;
    hit      = 9'h000;
    if (st.skip) begin
      // slash that closed a block comment
      r.st.skip = 1'b0;
    end else if (c == CuBslash && !st.esc) begin
      r.st.esc = 1'b1;
    end else begin
      if (!st.esc) begin
        if (c == CuDquote && !st.chr_lit && !st.line_cmt && !st.block_cmt) begin
          r.st.str_lit = !st.str_lit;
        end else if (c == CuSquote && !st.str_lit && !st.line_cmt && !st.block_cmt) begin
          r.st.chr_lit = !st.chr_lit;
        end else if (c == CuSlash && has_next && n == CuSlash && !st.str_lit &&
                     !st.chr_lit && !st.block_cmt) begin
          r.st.line_cmt = 1'b1;
        end else if (c == CuSlash && has_next && n == CuStar && !st.str_lit &&
                     !st.chr_lit && !st.line_cmt) begin
          r.st.block_cmt = 1'b1;
        end else if (c == CuStar && has_next && n == CuSlash && st.block_cmt) begin
          r.st.block_cmt = 1'b0;
          r.st.skip      = 1'b1;
          r.st.esc       = 1'b0;
          done           = 1'b1;
        end
      end
      if (!done) begin
        if (c == CuNewline && r.st.line_cmt) begin
          r.st.line_cmt = 1'b0;
        end
        r.st.esc = 1'b0;
        if (!r.st.str_lit && !r.st.chr_lit && !r.st.line_cmt && !r.st.block_cmt) begin
          hit = map_punct(c);
          if (hit[8]) begin
            r.unit   = {8'h00, hit[7:0]};
            r.mapped = 1'b1;
          end
        end
      end
    end
    return r;
  endfunction

endpackage

@@ src/fullwidth_punct_to_ascii_in_code.sv @@
// Maps full-width punctuation to ASCII outside literals and comments of source text.
// A word is held until the next word, its lookahead, is accepted, and is then registered;
//   a tlast word is registered at once, or parked in the spare slot behind a held word.
// Throughput: one word per cycle while the output is not stalled; while the spare slot
//   holds a word, no new word is accepted (single output register plus one spare slot).
// Reset: asynchronous, active low; clears flags, the held word and both output slots.
module fullwidth_punct_to_ascii_in_code
  import fpa_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  logic [UnitW-1:0] s_axis_tdata_i,   // [15:0] code_unit
  input  logic             s_axis_tlast_i,   // text_end
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  output logic [UnitW-1:0] m_axis_tdata_o,   // [15:0] out_unit
  output logic             m_axis_tuser_o,   // [0] was_mapped
  output logic             m_axis_tlast_o    // last_out
);

`include "assert_macros.svh"

  flags_t           st_q, st_d;
  logic             held_q, held_d;
  logic [UnitW-1:0] held_unit_q, held_unit_d;
  logic             out_vld_q, out_vld_d;
  res_t             out_q, out_d;
  logic             spare_q, spare_d;
  res_t             spare_res_q, spare_res_d;

  logic   accept;
  proc_t  p_held;
  proc_t  p_cur;
  flags_t st_mid;
  res_t   r_held;
  res_t   r_cur;

  // handshake: space in the output register and no spare word waiting
  assign s_axis_tready_o = !spare_q && (!out_vld_q || m_axis_tready_i);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  // held word with incoming lookahead, then incoming word without lookahead
  always_comb begin
    p_held = proc_unit(st_q, held_unit_q, 1'b1, s_axis_tdata_i);
    st_mid = held_q ? p_held.st : st_q;
    p_cur  = proc_unit(st_mid, s_axis_tdata_i, 1'b0, '0);
    r_held = '{unit: p_held.unit, mapped: p_held.mapped, last: 1'b0};
    r_cur  = '{unit: p_cur.unit, mapped: p_cur.mapped, last: 1'b1};
  end

  // scanner state update
  always_comb begin
    st_d        = st_q;
    held_d      = held_q;
    held_unit_d = held_unit_q;
    if (accept) begin
      if (s_axis_tlast_i) begin
        st_d   = '0;
        held_d = 1'b0;
      end else begin
        st_d        = st_mid;
        held_d      = 1'b1;
        held_unit_d = s_axis_tdata_i;
      end
    end
  end

  // output register and spare slot
  always_comb begin
    out_vld_d   = out_vld_q;
    out_d       = out_q;
    spare_d     = spare_q;
    spare_res_d = spare_res_q;
    if (accept) begin
      spare_d = 1'b0;
      if (held_q) begin
        out_vld_d = 1'b1;
        out_d     = r_held;
        if (s_axis_tlast_i) begin
          spare_d     = 1'b1;
          spare_res_d = r_cur;
        end
      end else if (s_axis_tlast_i) begin
        out_vld_d = 1'b1;
        out_d     = r_cur;
      end else begin
        out_vld_d = 1'b0;
      end
    end else if (spare_q && (!out_vld_q || m_axis_tready_i)) begin
      out_vld_d = 1'b1;
      out_d     = spare_res_q;
      spare_d   = 1'b0;
    end else if (m_axis_tready_i) begin
      out_vld_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= '0;
      held_q      <= 1'b0;
      held_unit_q <= '0;
      out_vld_q   <= 1'b0;
      spare_q     <= 1'b0;
    end else begin
      st_q        <= st_d;
      held_q      <= held_d;
      held_unit_q <= held_unit_d;
      out_vld_q   <= out_vld_d;
      spare_q     <= spare_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    out_q       <= out_d;
    spare_res_q <= spare_res_d;
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_q.unit;
  assign m_axis_tuser_o  = out_q.mapped;
  assign m_axis_tlast_o  = out_q.last;

  // checks
  `ASSERT_ON(a_spare_behind_out, spare_q |-> out_vld_q)
  `ASSERT_ON(a_spare_blocks_in, spare_q |-> !s_axis_tready_o)
  `ASSERT_ON(a_last_clears_held, (accept && s_axis_tlast_i) |=> (!held_q && st_q == '0))
  `ASSERT_ON(a_spare_from_flush, $rose(spare_q) |-> $past(accept && s_axis_tlast_i))
  `ASSERT_ALWAYS(a_spare_is_last, spare_q |-> spare_res_q.last)

endmodule

@@ dv/fullwidth_punct_to_ascii_in_code_tb.sv @@
// Self-checking testbench for the full-width punctuation mapper with random stream stalls
module fullwidth_punct_to_ascii_in_code_tb;
  import fpa_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ClkPeriod   = 8;
  localparam int unsigned RandomWords = 650;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned SettleWait  = 16;
  localparam int unsigned NumPunct    = 19;

  // full-width and cjk punctuation with their ascii counterparts
  localparam logic [UnitW-1:0] WidePunct [NumPunct] = '{
    16'hFF1B, 16'hFF1A, 16'hFF0C, 16'h3002, 16'hFF01, 16'hFF1F, 16'hFF08,
    16'hFF09, 16'h3010, 16'h3011, 16'h300A, 16'h300B, 16'h201C, 16'h201D,
    16'h2018, 16'h2019, 16'h3001, 16'hFF5B, 16'hFF5D
  };
  localparam logic [UnitW-1:0] AsciiPunct [NumPunct] = '{
    16'h003B, 16'h003A, 16'h002C, 16'h002E, 16'h0021, 16'h003F, 16'h0028,
    16'h0029, 16'h005B, 16'h005D, 16'h003C, 16'h003E, 16'h0022, 16'h0022,
    16'h0027, 16'h0027, 16'h005C, 16'h007B, 16'h007D
  };
  localparam logic [UnitW-1:0] SteerUnits [6] = '{
    CuBslash, CuDquote, CuSquote, CuSlash, CuStar, CuNewline
  };

  // one word waiting to be sent; hold means wait for all results first
  typedef struct {
    logic [UnitW-1:0] unit;
    logic             last;
    bit               hold;
  } src_word_t;

  // scanner context tracked by the predictor
  typedef struct packed {
    bit in_str;
    bit in_chr;
    bit in_line;
    bit in_block;
    bit esc;
    bit skip_slash;
  } lexer_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic             src_valid = 1'b0;
  logic [UnitW-1:0] src_data  = '0;
  logic             src_last  = 1'b0;
  logic             sink_ready = 1'b0;

  logic             s_axis_tready_o;
  logic             m_axis_tvalid_o;
  logic [UnitW-1:0] m_axis_tdata_o;
  logic             m_axis_tuser_o;
  logic             m_axis_tlast_o;

  src_word_t   pending_words[$];
  res_t        mapped_expect[$];
  lexer_t      lex;
  logic [UnitW-1:0] held_unit;
  bit          held_ok;
  int unsigned errors      = 0;
  int unsigned cycle_count = 0;

  fullwidth_punct_to_ascii_in_code dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (src_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (src_data),
    .s_axis_tlast_i  (src_last),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (sink_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // table lookup of a full-width unit
  function automatic bit ascii_equiv(input logic [UnitW-1:0] c, output logic [UnitW-1:0] a);
    a = c;
    for (int k = 0; k < NumPunct; k++) begin
      if (WidePunct[k] == c) begin
        a = AsciiPunct[k];
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // scan one unit with optional lookahead and queue its expected word
  function automatic void scan_unit(input logic [UnitW-1:0] c, input bit has_next,
                                    input logic [UnitW-1:0] nxt, input bit is_last);
    res_t             r;
    bit               closed;
    logic [UnitW-1:0] asc;
    r.unit   = c;
    r.mapped = 1'b0;
    r.last   = is_last;
    closed   = 1'b0;
    if (lex.skip_slash) begin
      lex.skip_slash = 1'b0;
    end else if (c == CuBslash && !lex.esc) begin
      lex.esc = 1'b1;
    end else begin
      if (!lex.esc) begin
        if (c == CuDquote && !lex.in_chr && !lex.in_line && !lex.in_block) begin
          lex.in_str = !lex.in_str;
        end else if (c == CuSquote && !lex.in_str && !lex.in_line && !lex.in_block) begin
          lex.in_chr = !lex.in_chr;
        end else if (c == CuSlash && has_next && nxt == CuSlash && !lex.in_str &&
                     !lex.in_chr && !lex.in_block) begin
          lex.in_line = 1'b1;
        end else if (c == CuSlash && has_next && nxt == CuStar && !lex.in_str &&
                     !lex.in_chr && !lex.in_line) begin
          lex.in_block = 1'b1;
        end else if (c == CuStar && has_next && nxt == CuSlash && lex.in_block) begin
          // closing slash goes through untouched
          lex.in_block   = 1'b0;
          lex.skip_slash = 1'b1;
          lex.esc        = 1'b0;
          closed         = 1'b1;
        end
      end
      if (!closed) begin
        if (c == CuNewline && lex.in_line) begin
          lex.in_line = 1'b0;
        end
        lex.esc = 1'b0;
        if (!lex.in_str && !lex.in_chr && !lex.in_line && !lex.in_block) begin
          if (ascii_equiv(c, asc)) begin
            r.unit   = asc;
            r.mapped = 1'b1;
          end
        end
      end
    end
    mapped_expect.push_back(r);
  endfunction

  // one accepted input word: flush the held unit, hold or finish the text
  function automatic void predict_word(input logic [UnitW-1:0] unit, input logic last);
    if (held_ok) begin
      scan_unit(held_unit, 1'b1, unit, 1'b0);
    end
    if (last) begin
      scan_unit(unit, 1'b0, '0, 1'b1);
      lex       = '0;
      held_ok   = 1'b0;
      held_unit = '0;
    end else begin
      held_unit = unit;
      held_ok   = 1'b1;
    end
  endfunction

  // idle length: mostly none or short, a few long
  function automatic int unsigned pick_pause();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 25);
  endfunction

  // unit of ordinary code: punctuation, letters, raw values
  function automatic logic [UnitW-1:0] plain_unit();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 35) begin
      return WidePunct[$urandom_range(0, NumPunct - 1)];
    end else if (r < 65) begin
      return 16'h0061 + 16'($urandom_range(0, 25));
    end else if (r < 72) begin
      return 16'h0020;
    end else if (r < 94) begin
      return 16'($urandom);
    end
    return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
  endfunction

  // any unit, steering characters included
  function automatic logic [UnitW-1:0] any_unit();
    if ($urandom_range(0, 99) < 40) begin
      return SteerUnits[$urandom_range(0, 5)];
    end
    return plain_unit();
  endfunction

  // queue a text, the last unit marked as its end
  task automatic push_text(input logic [UnitW-1:0] units[$], input bit hold);
    src_word_t w;
    foreach (units[i]) begin
      w.unit = units[i];
      w.last = (i == units.size() - 1);
      w.hold = hold && (i == 0);
      pending_words.push_back(w);
    end
  endtask

  // source side: one word per handshake, random gaps and bursts
  always @(posedge clk_i or negedge rst_ni) begin : drive_words
    src_word_t   w;
    int unsigned src_gap;
    int unsigned src_burst;
    if (!rst_ni) begin
      src_valid <= 1'b0;
      src_data  <= '0;
      src_last  <= 1'b0;
      src_gap   = 0;
      src_burst = 0;
      lex       = '0;
      held_ok   = 1'b0;
      held_unit = '0;
    end else begin
      if (src_valid && s_axis_tready_o) begin
        predict_word(src_data, src_last);
      end
      if (!src_valid || s_axis_tready_o) begin
        if (src_gap > 0) begin
          src_gap--;
          src_valid <= 1'b0;
        end else if (pending_words.size() > 0 &&
                     !(pending_words[0].hold && mapped_expect.size() > 0)) begin
          w = pending_words.pop_front();
          src_valid <= 1'b1;
          src_data  <= w.unit;
          src_last  <= w.last;
          if (src_burst > 0) begin
            src_burst--;
            src_gap = 0;
          end else begin
            if ($urandom_range(0, 99) < 4) begin
              src_burst = $urandom_range(20, 60);
            end
            src_gap = pick_pause();
          end
        end else begin
          src_valid <= 1'b0;
        end
      end
    end
  end

  // result side: random stalls, compare each word with the oldest expectation
  always @(posedge clk_i or negedge rst_ni) begin : check_words
    res_t        want;
    int unsigned sink_stall;
    int unsigned sink_burst;
    if (!rst_ni) begin
      sink_ready <= 1'b0;
      sink_stall = 0;
      sink_burst = 0;
    end else begin
      if (m_axis_tvalid_o && sink_ready) begin
        if (mapped_expect.size() == 0) begin
          $error("unexpected word: out_unit %h was_mapped %b last_out %b",
                 m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o);
          errors++;
        end else begin
          want = mapped_expect.pop_front();
          if (m_axis_tdata_o !== want.unit) begin
            $error("out_unit: expected %h, actual %h", want.unit, m_axis_tdata_o);
            errors++;
          end
          if (m_axis_tuser_o !== want.mapped) begin
            $error("was_mapped: expected %b, actual %b", want.mapped, m_axis_tuser_o);
            errors++;
          end
          if (m_axis_tlast_o !== want.last) begin
            $error("last_out: expected %b, actual %b", want.last, m_axis_tlast_o);
            errors++;
          end
        end
      end
      if (sink_stall > 0) begin
        sink_stall--;
        sink_ready <= 1'b0;
      end else begin
        sink_ready <= 1'b1;
        if (sink_burst > 0) begin
          sink_burst--;
        end else begin
          if ($urandom_range(0, 99) < 4) begin
            sink_burst = $urandom_range(20, 60);
          end
          sink_stall = pick_pause();
        end
      end
    end
  end

  // watchdog on the cycle count
  initial begin : watchdog
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("fullwidth_punct_to_ascii_in_code_tb: FAIL");
    $finish;
  end

  // stimulus and end of run
  initial begin : stimulus
    logic [UnitW-1:0] text[$];
    int unsigned      random_count;
    int unsigned      frags;
    int unsigned      n;

    // raw extremes of the unit
    text = '{16'h0000, 16'hFFFF};
    push_text(text, 1'b0);
    // single unit text, mapped, nothing held
    text = '{16'hFF1B};
    push_text(text, 1'b0);
    // punctuation inside a string stays, outside it maps
    text = '{CuDquote, 16'hFF0C, CuDquote, 16'h3002};
    push_text(text, 1'b0);
    // line comment closed by newline
    text = '{CuSlash, CuSlash, 16'hFF1A, CuNewline, 16'hFF01};
    push_text(text, 1'b0);
    // block comment, closing slash passes through
    text = '{CuSlash, CuStar, 16'h201C, CuStar, CuSlash, 16'h2018};
    push_text(text, 1'b0);
    // escaped quote in a char literal, slash at the end sees no lookahead
    text = '{CuSquote, CuBslash, CuSquote, CuSquote, 16'h3001, CuSlash};
    push_text(text, 1'b0);

    // random texts built from fragments of code, literals and comments
    random_count = 0;
    while (random_count < RandomWords) begin
      text  = {};
      frags = $urandom_range(1, 5);
      for (int f = 0; f < frags; f++) begin
        n = $urandom_range(0, 6);
        case ($urandom_range(0, 9))
          0, 1: begin
            for (int i = 0; i < n; i++) text.push_back(plain_unit());
          end
          2: begin
            text.push_back(CuDquote);
            for (int i = 0; i < n; i++) begin
              if ($urandom_range(0, 99) < 15) text.push_back(CuBslash);
              text.push_back(plain_unit());
            end
            text.push_back(CuDquote);
          end
          3: begin
            text.push_back(CuSquote);
            if ($urandom_range(0, 99) < 30) text.push_back(CuBslash);
            text.push_back(any_unit());
            text.push_back(CuSquote);
          end
          4: begin
            text.push_back(CuSlash);
            text.push_back(CuSlash);
            for (int i = 0; i < n; i++) text.push_back(plain_unit());
            if ($urandom_range(0, 99) < 20) text.push_back(CuBslash);
            text.push_back(CuNewline);
          end
          5, 6: begin
            text.push_back(CuSlash);
            text.push_back(CuStar);
            for (int i = 0; i < n; i++) begin
              text.push_back(($urandom_range(0, 99) < 20) ? any_unit() : plain_unit());
            end
            text.push_back(CuStar);
            text.push_back(CuSlash);
          end
          default: begin
            for (int i = 0; i < n + 1; i++) text.push_back(any_unit());
          end
        endcase
      end
      if (text.size() == 0) text.push_back(any_unit());
      push_text(text, (random_count == 0) || ($urandom_range(0, 99) < 3));
      random_count += text.size();
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_words.size() > 0 || src_valid || mapped_expect.size() > 0) begin
      @(posedge clk_i);
    end
    repeat (SettleWait) @(posedge clk_i);

    if (errors == 0 && mapped_expect.size() == 0) begin
      $display("fullwidth_punct_to_ascii_in_code_tb: PASS");
    end else begin
      $display("fullwidth_punct_to_ascii_in_code_tb: FAIL");
    end
    $finish;
  end

endmodule
